>>> design/assert_macros.svh
// Assertion macros of the token scanner design files.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define JTS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define JTS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

>>> design/jts_pkg.sv
// Types, codes and character tables of the token scanner.
// No dependencies; imported by every module of the block.
package jts_pkg;

	localparam int NUM_KW    = 21;
	localparam int NUM_PUNCT = 19;
	localparam int KW_CHARS  = 11;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int LEVEL_W   = $clog2(QDEPTH + 1);

	typedef logic [5:0] kind_t;
	typedef logic [NUM_KW-1:0] kw_mask_t;

	localparam kind_t KIND_PUNCT_BASE = 6'd21;
	localparam kind_t KIND_SLASH      = 6'd29;
	localparam kind_t KIND_NAME       = 6'd40;
	localparam kind_t KIND_INT        = 6'd41;
	localparam kind_t KIND_STRING     = 6'd42;
	localparam kind_t KIND_EOF        = 6'd43;
	localparam kind_t KIND_STRAY      = 6'd44;
	localparam kind_t KIND_TEXT       = 6'd45;

	localparam kw_mask_t KW_ALL = '1;
	localparam logic [LEVEL_W-1:0] QLEVEL_MAX = LEVEL_W'(QDEPTH);

	localparam logic [7:0] CH_SLASH      = "/";
	localparam logic [7:0] CH_STAR       = "*";
	localparam logic [7:0] CH_QUOTE      = "\"";
	localparam logic [7:0] CH_UNDERSCORE = "_";
	localparam logic [7:0] CH_NEWLINE    = 8'd10;

	// Keywords in token code order; each is right-justified, first character highest.
	localparam logic [8*KW_CHARS-1:0] KW_STR [NUM_KW] = '{
		"class", "method", "function", "constructor", "int", "boolean", "char",
		"void", "var", "static", "field", "let", "do", "if", "else", "while",
		"return", "true", "false", "null", "this"
	};
	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd5, 4'd6, 4'd8, 4'd11, 4'd3, 4'd7, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5,
		4'd3, 4'd2, 4'd2, 4'd4, 4'd5, 4'd6, 4'd4, 4'd5, 4'd4, 4'd4
	};
	localparam logic [7:0] PUNCT_CHAR [NUM_PUNCT] = '{
		"&", "(", ")", "*", "+", ",", "-", ".", "/", ";", "<", "=", ">", "[",
		"]", "{", "|", "}", "~"
	};

	typedef enum logic [7:0] {
		ST_START     = 8'b0000_0001,
		ST_SLASH     = 8'b0000_0010,
		ST_LINE      = 8'b0000_0100,
		ST_BLOCK     = 8'b0000_1000,
		ST_BLOCK_END = 8'b0001_0000,
		ST_STRING    = 8'b0010_0000,
		ST_NUMBER    = 8'b0100_0000,
		ST_NAME      = 8'b1000_0000
	} lex_state_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [7:0]  text_byte;
		logic [15:0] int_value;
		logic        int_overflow;
		logic [15:0] line_number;
		logic [15:0] column_number;
		logic        last_of_run;
	} out_item_t;

	// All results caused by one source character.
	typedef struct packed {
		kind_t       kind0;
		kind_t       kind1;
		logic        two;
		logic [7:0]  text;
		logic [15:0] int_value;
		logic        int_overflow;
		logic [15:0] line;
		logic [15:0] col;
	} bundle_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               second;
	} qstat_t;

	typedef struct packed {
		logic       emit;
		kind_t      kind;
		lex_state_t state;
	} start_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {["a":"z"], ["A":"Z"]};
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c inside {" ", [8'd9:8'd13]};
	endfunction

	// Keywords whose character at position pos equals c.
	function automatic kw_mask_t kw_match(input logic [3:0] pos, input logic [7:0] c);
		kw_mask_t m;
		int       idx;
		m = '0;
		for (int k = 0; k < NUM_KW; k++) begin
			if (pos < KW_LEN[k]) begin
				idx = int'(KW_LEN[k]) - 1 - int'(pos);
				m[k] = (KW_STR[k][idx*8 +: 8] == c);
			end
		end
		return m;
	endfunction

	// Decision for a character met in the start state.
	function automatic start_t start_class(input logic [7:0] c);
		start_t s;
		s.emit  = 1'b0;
		s.kind  = KIND_STRAY;
		s.state = ST_START;
		if (c == CH_SLASH) begin
			s.state = ST_SLASH;
		end else if (c == CH_QUOTE) begin
			s.state = ST_STRING;
		end else if (is_digit(c)) begin
			s.state = ST_NUMBER;
		end else if (is_alpha(c) || c == CH_UNDERSCORE) begin
			s.state = ST_NAME;
			s.emit  = 1'b1;
			s.kind  = KIND_TEXT;
		end else if (!is_space(c)) begin
			s.emit = 1'b1;
			for (int k = 0; k < NUM_PUNCT; k++) begin
				if (PUNCT_CHAR[k] == c) begin
					s.kind = KIND_PUNCT_BASE + 6'(k);
				end
			end
		end
		return s;
	endfunction

endpackage

>>> design/jts_front.sv
// Front end of the token scanner: lexer state, keyword tracking, number and position counters.
// Depends on jts_pkg; hands one bundle of up to two results per character to jts_back.
module jts_front import jts_pkg::*; #(
	parameter int VALUE_WIDTH    = 16,
	parameter int POSITION_WIDTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t item,
	input  logic     q_full,
	output logic     bundle_push,
	output bundle_t  bundle
);

	localparam int VW = VALUE_WIDTH;
	localparam int PW = POSITION_WIDTH;

	lex_state_t      st_q, st_n;
	kw_mask_t        ka_q, ka_n;
	logic [3:0]      len_q, len_n;
	logic [VW-1:0]   acc_q, acc_n;
	logic            ovf_q, ovf_n;
	logic [PW-1:0]   line_q, line_n;
	logic [PW-1:0]   col_q, col_n;

	logic            accept;
	logic [7:0]      c;
	start_t          sc;
	logic [VW+3:0]   prod;
	kind_t           k0, k1, name_kind;
	logic [1:0]      nres;
	logic            do_start, second;
	logic [VW-1:0]   ival;
	logic            iovf;
	logic [VW+15:0]  ival_ext;
	logic [PW+15:0]  line_ext, col_ext;

	assign accept = push && !q_full;
	assign c      = item.char_byte;
	assign sc     = start_class(c);

	// acc * 10 + digit; anything in the top four bits means the value no longer fits.
	assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (VW+4)'(c[3:0]);

	// The first live keyword of matching length wins; otherwise it is a plain name.
	always_comb begin
		name_kind = KIND_NAME;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (ka_q[k] && KW_LEN[k] == len_q) begin
				name_kind = 6'(k);
			end
		end
	end

	always_comb begin
		st_n     = st_q;
		ka_n     = ka_q;
		len_n    = len_q;
		acc_n    = acc_q;
		ovf_n    = ovf_q;
		line_n   = line_q;
		col_n    = col_q;
		k0       = KIND_EOF;
		k1       = KIND_EOF;
		nres     = 2'd0;
		do_start = 1'b0;
		second   = 1'b0;
		ival     = '0;
		iovf     = 1'b0;
		if (item.end_of_input) begin
			st_n  = ST_START;
			ka_n  = KW_ALL;
			len_n = 4'd0;
			acc_n = '0;
			ovf_n = 1'b0;
			k0    = KIND_EOF;
			nres  = 2'd1;
		end else begin
			if (c == CH_NEWLINE) begin
				col_n = '0;
				if (!(&line_q)) begin
					line_n = line_q + PW'(1);
				end
			end else if (!(&col_q)) begin
				col_n = col_q + PW'(1);
			end
			case (st_q)
				ST_START: begin
					do_start = 1'b1;
				end
				ST_SLASH: begin
					if (c == CH_SLASH) begin
						st_n = ST_LINE;
					end else if (c == CH_STAR) begin
						st_n = ST_BLOCK;
					end else begin
						k0       = KIND_SLASH;
						nres     = 2'd1;
						do_start = 1'b1;
						second   = 1'b1;
					end
				end
				ST_LINE: begin
					if (c == CH_NEWLINE) begin
						st_n = ST_START;
					end
				end
				ST_BLOCK: begin
					if (c == CH_STAR) begin
						st_n = ST_BLOCK_END;
					end
				end
				ST_BLOCK_END: begin
					st_n = (c == CH_SLASH) ? ST_START : ST_BLOCK;
				end
				ST_STRING: begin
					nres = 2'd1;
					if (c == CH_QUOTE) begin
						st_n = ST_START;
						k0   = KIND_STRING;
					end else begin
						k0 = KIND_TEXT;
					end
				end
				ST_NUMBER: begin
					if (is_digit(c)) begin
						if (prod[VW+3:VW] != 4'd0) begin
							acc_n = '1;
							ovf_n = 1'b1;
						end else begin
							acc_n = prod[VW-1:0];
						end
					end else begin
						k0       = KIND_INT;
						ival     = acc_q;
						iovf     = ovf_q;
						nres     = 2'd1;
						acc_n    = '0;
						ovf_n    = 1'b0;
						do_start = 1'b1;
						second   = 1'b1;
					end
				end
				ST_NAME: begin
					nres = 2'd1;
					if (is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE) begin
						ka_n = ka_q & kw_match(len_q, c);
						if (len_q != 4'd15) begin
							len_n = len_q + 4'd1;
						end
						k0 = KIND_TEXT;
					end else begin
						k0       = name_kind;
						ka_n     = KW_ALL;
						len_n    = 4'd0;
						do_start = 1'b1;
						second   = 1'b1;
					end
				end
				default: begin
					do_start = 1'b1;
				end
			endcase
			// The character that ended a token is taken again from the start state.
			if (do_start) begin
				st_n = sc.state;
				if (sc.state == ST_NUMBER) begin
					acc_n = {{(VW-4){1'b0}}, c[3:0]};
					ovf_n = 1'b0;
				end
				if (sc.state == ST_NAME) begin
					ka_n  = kw_match(4'd0, c);
					len_n = 4'd1;
				end
				if (sc.emit) begin
					if (second) begin
						k1   = sc.kind;
						nres = 2'd2;
					end else begin
						k0   = sc.kind;
						nres = 2'd1;
					end
				end
			end
		end
	end

	assign ival_ext = {16'b0, ival};
	assign line_ext = {16'b0, line_n};
	assign col_ext  = {16'b0, col_n};

	always_comb begin
		bundle.kind0        = k0;
		bundle.kind1        = k1;
		bundle.two          = (nres == 2'd2);
		bundle.text         = c;
		bundle.int_value    = ival_ext[15:0];
		bundle.int_overflow = iovf;
		bundle.line         = line_ext[15:0];
		bundle.col          = col_ext[15:0];
	end

	assign bundle_push = accept && (nres != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_START;
			ka_q   <= KW_ALL;
			len_q  <= 4'd0;
			acc_q  <= '0;
			ovf_q  <= 1'b0;
			line_q <= PW'(1);
			col_q  <= '0;
		end else if (accept) begin
			st_q   <= st_n;
			ka_q   <= ka_n;
			len_q  <= len_n;
			acc_q  <= acc_n;
			ovf_q  <= ovf_n;
			line_q <= line_n;
			col_q  <= col_n;
		end
	end

endmodule

>>> design/jts_back.sv
// Back end of the token scanner: result queue and one-result-per-transfer unpacking.
// Depends on jts_pkg; fed by jts_front with bundles of one or two results.
module jts_back import jts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      bundle_push,
	input  bundle_t   bundle,
	output logic      q_full,
	output logic      empty,
	input  logic      pop,
	output out_item_t result,
	output qstat_t    stat
);

	bundle_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [LEVEL_W-1:0]   level_q;
	logic                 sub_q;

	bundle_t              head;
	kind_t                kind;
	logic                 last;
	logic                 xfer, deq;

	assign head   = mem_q[rd_ptr_q];
	assign empty  = (level_q == '0);
	assign q_full = (level_q == QLEVEL_MAX);
	assign kind   = sub_q ? head.kind1 : head.kind0;
	assign last   = !(head.two && !sub_q);
	assign xfer   = pop && !empty;
	assign deq    = xfer && last;

	always_comb begin
		result.token_kind    = kind;
		result.text_byte     = (kind == KIND_TEXT) ? head.text : 8'd0;
		result.int_value     = (kind == KIND_INT) ? head.int_value : 16'd0;
		result.int_overflow  = (kind == KIND_INT) && head.int_overflow;
		result.line_number   = head.line;
		result.column_number = head.col;
		result.last_of_run   = last;
	end

	assign stat.level  = level_q;
	assign stat.second = sub_q;

	always_ff @(posedge clk) begin
		if (bundle_push) begin
			mem_q[wr_ptr_q] <= bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
			sub_q    <= 1'b0;
		end else begin
			if (bundle_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (bundle_push && !deq) begin
				level_q <= level_q + LEVEL_W'(1);
			end else if (deq && !bundle_push) begin
				level_q <= level_q - LEVEL_W'(1);
			end
			// A two-result entry stays at the head until its second transfer.
			if (xfer) begin
				sub_q <= !last;
			end
		end
	end

endmodule

>>> design/jack_token_scanner_top.sv
// Latency: a result can be taken in the cycle after its character's transfer.
// Throughput: one character per cycle while full is low and each gives at most one result;
// one giving two results takes two result transfers, paced by the single result port.
// A four-entry queue of result bundles lets the front end keep taking characters meanwhile.
// Reset (arst_n low, asynchronous): lexer at start, line 1, column 0, queue empty.
`include "assert_macros.svh"

module jack_token_scanner_top import jts_pkg::*; #(
	parameter int VALUE_WIDTH    = 16,
	parameter int POSITION_WIDTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic    bundle_push;
	bundle_t bundle;
	qstat_t  stat;

	jts_front #(
		.VALUE_WIDTH   (VALUE_WIDTH),
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item       (item),
		.q_full     (full),
		.bundle_push(bundle_push),
		.bundle     (bundle)
	);

	jts_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.bundle_push(bundle_push),
		.bundle     (bundle),
		.q_full     (full),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.stat       (stat)
	);

	`JTS_ASSERT(a_level_bound, clk, arst_n, stat.level <= QLEVEL_MAX, "result queue overfilled")
	`JTS_ASSERT_NEVER(a_second_needs_entry, clk, arst_n, stat.second && empty, "second result pending on empty queue")
	`JTS_ASSERT(a_pair_follows, clk, arst_n, (pop && !empty && !result.last_of_run) |=> !empty, "second result of a pair was lost")
	`JTS_ASSERT(a_eof_last, clk, arst_n, (!empty && result.token_kind == KIND_EOF) |-> result.last_of_run, "end of file is not the last result of its character")

endmodule

>>> test/testbench.sv
// Self-checking testbench of the Jack token scanner: directed and random source text,
// a character-level predictor in a scoreboard class, and random stalls on both queue sides.
// Depends on jts_pkg and jack_token_scanner_top.
`timescale 1ns / 100ps

module testbench;
	import jts_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1800;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned HOLD_AT      = 600;
	localparam int unsigned HOLD_CYCLES  = 200;
	localparam int unsigned TAIL_CYCLES  = 8;

	class token_predictor;
		out_item_t   pending_tokens[$];
		out_item_t   step_tokens[$];
		int unsigned errors;
		string       kw_names[NUM_KW];
		string       punct_chars;
		lex_state_t  scan_mode;
		kw_mask_t    kw_live;
		logic [3:0]  name_len;
		int unsigned num_value;
		logic        num_sat;
		logic [15:0] line_no;
		logic [15:0] col_no;

		function new();
			kw_names = '{"class", "method", "function", "constructor", "int", "boolean",
				"char", "void", "var", "static", "field", "let", "do", "if", "else",
				"while", "return", "true", "false", "null", "this"};
			punct_chars = "&()*+,-./;<=>[]{|}~";
			errors = 0;
			scan_mode = ST_START;
			kw_live = '1;
			name_len = '0;
			num_value = 0;
			num_sat = 1'b0;
			line_no = 16'd1;
			col_no = '0;
		endfunction

		function bit digit(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit letter(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		function bit blank(logic [7:0] c);
			return c == " " || (c >= 8'd9 && c <= 8'd13);
		endfunction

		function void add(kind_t kind, logic [7:0] text, logic [15:0] value, logic sat);
			out_item_t r;
			r.token_kind = kind;
			r.text_byte = text;
			r.int_value = value;
			r.int_overflow = sat;
			r.line_number = line_no;
			r.column_number = col_no;
			r.last_of_run = 1'b0;
			step_tokens.push_back(r);
		endfunction

		function void name_char(logic [7:0] c);
			for (int k = 0; k < NUM_KW; k++) begin
				if (name_len >= kw_names[k].len() || kw_names[k][name_len] != c)
					kw_live[k] = 1'b0;
			end
			if (name_len != 4'd15)
				name_len++;
			add(KIND_TEXT, c, '0, 1'b0);
		endfunction

		function kind_t name_kind();
			for (int k = 0; k < NUM_KW; k++) begin
				if (kw_live[k] && kw_names[k].len() == name_len)
					return kind_t'(k);
			end
			return KIND_NAME;
		endfunction

		function void start_char(logic [7:0] c);
			bit hit;
			hit = 1'b0;
			scan_mode = ST_START;
			if (c == "/") begin
				scan_mode = ST_SLASH;
			end else if (c == CH_QUOTE) begin
				scan_mode = ST_STRING;
			end else if (digit(c)) begin
				num_value = c - "0";
				num_sat = 1'b0;
				scan_mode = ST_NUMBER;
			end else if (letter(c) || c == "_") begin
				kw_live = '1;
				name_len = '0;
				scan_mode = ST_NAME;
				name_char(c);
			end else if (!blank(c)) begin
				for (int k = 0; k < NUM_PUNCT; k++) begin
					if (!hit && punct_chars[k] == c) begin
						add(kind_t'(KIND_PUNCT_BASE + k), '0, '0, 1'b0);
						hit = 1'b1;
					end
				end
				if (!hit)
					add(KIND_STRAY, '0, '0, 1'b0);
			end
		endfunction

		// Works out the results of one accepted character and queues them.
		function void take_char(in_item_t ch);
			logic [7:0]  c;
			int unsigned d;
			c = ch.char_byte;
			step_tokens.delete();
			if (ch.end_of_input) begin
				scan_mode = ST_START;
				kw_live = '1;
				name_len = '0;
				num_value = 0;
				num_sat = 1'b0;
				add(KIND_EOF, '0, '0, 1'b0);
			end else begin
				if (c == CH_NEWLINE) begin
					col_no = '0;
					if (line_no != 16'hFFFF)
						line_no++;
				end else if (col_no != 16'hFFFF) begin
					col_no++;
				end
				case (scan_mode)
					ST_START: begin
						start_char(c);
					end
					ST_SLASH: begin
						if (c == "/") begin
							scan_mode = ST_LINE;
						end else if (c == "*") begin
							scan_mode = ST_BLOCK;
						end else begin
							add(KIND_SLASH, '0, '0, 1'b0);
							start_char(c);
						end
					end
					ST_LINE: begin
						if (c == CH_NEWLINE)
							scan_mode = ST_START;
					end
					ST_BLOCK: begin
						if (c == "*")
							scan_mode = ST_BLOCK_END;
					end
					ST_BLOCK_END: begin
						scan_mode = (c == "/") ? ST_START : ST_BLOCK;
					end
					ST_STRING: begin
						if (c == CH_QUOTE) begin
							scan_mode = ST_START;
							add(KIND_STRING, '0, '0, 1'b0);
						end else begin
							add(KIND_TEXT, c, '0, 1'b0);
						end
					end
					ST_NUMBER: begin
						if (digit(c)) begin
							d = c - "0";
							if (num_value > (32'd65535 - d) / 10) begin
								num_value = 32'd65535;
								num_sat = 1'b1;
							end else begin
								num_value = num_value * 10 + d;
							end
						end else begin
							add(KIND_INT, '0, num_value[15:0], num_sat);
							num_value = 0;
							num_sat = 1'b0;
							start_char(c);
						end
					end
					default: begin
						if (letter(c) || digit(c) || c == "_") begin
							name_char(c);
						end else begin
							add(name_kind(), '0, '0, 1'b0);
							kw_live = '1;
							name_len = '0;
							start_char(c);
						end
					end
				endcase
			end
			if (step_tokens.size() > 0)
				step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
			foreach (step_tokens[i])
				pending_tokens.push_back(step_tokens[i]);
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_token(out_item_t got);
			out_item_t want;
			if (pending_tokens.size() == 0) begin
				$error("unexpected result: token_kind %0d", got.token_kind);
				errors++;
				return;
			end
			want = pending_tokens.pop_front();
			check_field("token_kind", want.token_kind, got.token_kind);
			check_field("text_byte", want.text_byte, got.text_byte);
			check_field("int_value", want.int_value, got.int_value);
			check_field("int_overflow", want.int_overflow, got.int_overflow);
			check_field("line_number", want.line_number, got.line_number);
			check_field("column_number", want.column_number, got.column_number);
			check_field("last_of_run", want.last_of_run, got.last_of_run);
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	out_item_t result;

	token_predictor tokens;
	in_item_t       char_stream[$];
	string          name_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
	string          blanks = " \t\n\v\f\r";
	int unsigned    cycle_count = 0;

	jack_token_scanner_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #5 clk = ~clk;

	function automatic void put_char(logic [7:0] c);
		in_item_t ch;
		ch.char_byte = c;
		ch.end_of_input = 1'b0;
		char_stream.push_back(ch);
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i]);
	endfunction

	// The character byte rides along at random; the scanner must ignore it.
	function automatic void put_end();
		in_item_t ch;
		ch.char_byte = 8'($urandom_range(255));
		ch.end_of_input = 1'b1;
		char_stream.push_back(ch);
	endfunction

	function automatic void put_random_token();
		int unsigned pick;
		int unsigned n;
		string       kw;
		logic [7:0]  c;
		pick = $urandom_range(99);
		if (pick < 15) begin
			put_text(tokens.kw_names[$urandom_range(NUM_KW - 1)]);
		end else if (pick < 20) begin
			// Near misses: a keyword cut short or running on.
			kw = tokens.kw_names[$urandom_range(NUM_KW - 1)];
			if ($urandom_range(1)) begin
				put_text(kw.substr(0, kw.len() - 2));
			end else begin
				put_text(kw);
				put_char(name_chars[$urandom_range(name_chars.len() - 1)]);
			end
		end else if (pick < 35) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(13, 18) : $urandom_range(1, 8);
			put_char(name_chars[$urandom_range(52)]);
			for (int i = 1; i < n; i++)
				put_char(name_chars[$urandom_range(name_chars.len() - 1)]);
		end else if (pick < 47) begin
			case ($urandom_range(9))
				0: put_text("65535");
				1: put_text("65536");
				2: begin
					put_text("6553");
					put_char(8'("0" + $urandom_range(9)));
				end
				default: begin
					n = $urandom_range(1, 7);
					for (int i = 0; i < n; i++)
						put_char(8'("0" + $urandom_range(9)));
				end
			endcase
		end else if (pick < 55) begin
			put_char(CH_QUOTE);
			n = $urandom_range(8);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(9))
					0: c = CH_NEWLINE;
					1, 2: c = 8'($urandom_range(255));
					default: c = 8'($urandom_range(32, 126));
				endcase
				put_char((c == CH_QUOTE) ? 8'("x") : c);
			end
			if ($urandom_range(9) != 0)
				put_char(CH_QUOTE);
		end else if (pick < 60) begin
			put_text("//");
			n = $urandom_range(6);
			for (int i = 0; i < n; i++)
				put_char(8'($urandom_range(32, 126)));
			put_char(CH_NEWLINE);
		end else if (pick < 65) begin
			kw = "ab */\n*";
			put_text("/*");
			n = $urandom_range(6);
			for (int i = 0; i < n; i++)
				put_char(kw[$urandom_range(kw.len() - 1)]);
			put_text("*/");
		end else if (pick < 80) begin
			put_char(tokens.punct_chars[$urandom_range(NUM_PUNCT - 1)]);
		end else if (pick < 85) begin
			put_char("/");
		end else if (pick < 90) begin
			put_char(blanks[$urandom_range(blanks.len() - 1)]);
		end else if (pick < 94) begin
			case ($urandom_range(3))
				0: put_char(8'($urandom_range(8)));
				1: put_char(8'($urandom_range(14, 31)));
				2: put_char(8'd127);
				default: put_char(8'($urandom_range(128, 255)));
			endcase
		end else if (pick < 98) begin
			put_char(8'($urandom_range(255)));
		end else begin
			put_end();
		end
		if ($urandom_range(1))
			put_char(blanks[$urandom_range(blanks.len() - 1)]);
	endfunction

	task automatic feed_char(input in_item_t ch, input bit calm);
		while (!calm && $urandom_range(99) < 25) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= ch;
		do @(posedge clk); while (full);
		tokens.take_char(ch);
	endtask

	initial begin : source_side
		int unsigned random_start;
		int unsigned random_end;
		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		tokens = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Keyword, saturating constant ended by a slash, slash then name, name ended by a
		// quote, string across a newline, empty block comment, stray bytes, end mid-name.
		put_text("class 65536/_\"a\n\"/**/");
		put_char(8'h80);
		put_char(8'h00);
		put_char("~");
		put_text("x9");
		put_end();

		random_start = char_stream.size();
		random_end = random_start + RANDOM_ITEMS;
		while (char_stream.size() < random_end)
			put_random_token();
		put_end();

		foreach (char_stream[i])
			feed_char(char_stream[i], i >= random_start + 700 && i < random_start + 1100);
		push <= 1'b0;

		while (tokens.pending_tokens.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tokens.pending_tokens.size() != 0) begin
			$error("%0d expected results never arrived", tokens.pending_tokens.size());
			tokens.errors++;
		end
		if (tokens.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin : result_side
		int unsigned sink_cycles;
		int unsigned hold;
		bit          calm;
		sink_cycles = 0;
		hold = 0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			// One long hold-off lets the output queue fill and back up the input.
			if (sink_cycles == HOLD_AT)
				hold = HOLD_CYCLES;
			calm = sink_cycles >= 1500 && sink_cycles < 2000;
			if (hold != 0) begin
				pop <= 1'b0;
				hold--;
			end else begin
				pop <= calm || $urandom_range(99) >= 25;
			end
			@(posedge clk);
			sink_cycles++;
			if (pop && !empty)
				tokens.check_token(result);
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
